// ----- rtl/core/pid_controller_clamped_defines.svh -----
// Assertion helpers for the PID controller core.
// Each macro expects clk and arst_n in the scope where it is used.
`ifndef PID_CONTROLLER_CLAMPED_DEFINES_SVH
`define PID_CONTROLLER_CLAMPED_DEFINES_SVH

// Same-cycle implication
`define PIDC_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication
`define PIDC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/core/pidc_pkg.sv -----
package pidc_pkg;

	// Default number format
	localparam int DATA_WIDTH_DEF = 32;
	localparam int FRAC_BITS_DEF  = 16;

	// Multiplier consumes this many bits of the second operand per cycle
	localparam int MUL_CHUNK = 16;

	// Configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	// Microprogram
	localparam int PC_W = 5;

	// ALU operations
	typedef logic [2:0] alu_op_t;
	localparam alu_op_t OP_NOP   = 3'd0;
	localparam alu_op_t OP_SUB   = 3'd1;
	localparam alu_op_t OP_ADD   = 3'd2;
	localparam alu_op_t OP_MUL   = 3'd3;
	localparam alu_op_t OP_CLMPA = 3'd4;
	localparam alu_op_t OP_CLMPO = 3'd5;
	localparam alu_op_t OP_ZERO  = 3'd6;
	localparam alu_op_t OP_MOVE  = 3'd7;

	// Operand sources
	typedef logic [3:0] src_t;
	localparam src_t SRC_TGT  = 4'd0;
	localparam src_t SRC_MEAS = 4'd1;
	localparam src_t SRC_ERR  = 4'd2;
	localparam src_t SRC_T    = 4'd3;
	localparam src_t SRC_U    = 4'd4;
	localparam src_t SRC_ACC  = 4'd5;
	localparam src_t SRC_LAST = 4'd6;
	localparam src_t SRC_STEP = 4'd7;
	localparam src_t SRC_PG   = 4'd8;
	localparam src_t SRC_IG   = 4'd9;
	localparam src_t SRC_DG   = 4'd10;

	// Result destinations
	typedef logic [2:0] dst_t;
	localparam dst_t DST_NONE = 3'd0;
	localparam dst_t DST_ERR  = 3'd1;
	localparam dst_t DST_T    = 3'd2;
	localparam dst_t DST_U    = 3'd3;
	localparam dst_t DST_ACC  = 3'd4;
	localparam dst_t DST_LAST = 3'd5;

	// Jump conditions
	typedef logic [1:0] jmp_t;
	localparam jmp_t JMP_NONE = 2'd0;
	localparam jmp_t JMP_CLR  = 2'd1;
	localparam jmp_t JMP_DT0  = 2'd2;

	// One microcode control word
	typedef struct packed {
		alu_op_t         op;
		src_t            a_sel;
		src_t            b_sel;
		dst_t            dst;
		jmp_t            jmp;
		logic [PC_W-1:0] target;
		logic            last;
	} uword_t;

	// Sequencer to datapath
	typedef struct packed {
		uword_t uw;
		logic   wr;
		logic   mul_start;
	} ctl_t;

	// Datapath to sequencer
	typedef struct packed {
		logic clr;
		logic dt0;
	} sts_t;

endpackage

// ----- rtl/core/pidc_mul.sv -----
// Saturating fixed-point multiplier, one chunk of the second operand per cycle.
module pidc_mul #(
	parameter int DATA_WIDTH = pidc_pkg::DATA_WIDTH_DEF,
	parameter int FRAC_BITS  = pidc_pkg::FRAC_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic signed [DATA_WIDTH-1:0] a,
	input  logic signed [DATA_WIDTH-1:0] b,
	output logic                         done,
	output logic signed [DATA_WIDTH-1:0] result
);
	import pidc_pkg::*;

	localparam int DW    = DATA_WIDTH;
	localparam int CW    = MUL_CHUNK;
	localparam int NCH   = (DW + CW - 1) / CW;
	localparam int UW    = NCH * CW;
	localparam int PW    = DW + UW;
	localparam int DPW   = DW + CW;
	localparam int CNT_W = $clog2(NCH + 1);
	localparam logic [PW-1:0] LIMIT_P = PW'(1) << (DW - 1);
	localparam logic [DW-1:0] MAXV    = {1'b0, {(DW-1){1'b1}}};

	logic [DW-1:0]    ua_q;
	logic [UW-1:0]    ub_q;
	logic [PW-1:0]    prod_q;
	logic             neg_q;
	logic             run_q;
	logic             fin_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DW-1:0]    result_q;

	logic [DW-1:0]  mag_a;
	logic [DW-1:0]  mag_b;
	logic [DPW-1:0] pp;
	logic [PW-1:0]  shifted;
	logic [DW-1:0]  rsat;
	logic [DW-1:0]  res_n;

	// Magnitudes, partial product and final truncation/saturation
	always_comb begin
		mag_a   = a[DW-1] ? (~a + DW'(1)) : a;
		mag_b   = b[DW-1] ? (~b + DW'(1)) : b;
		pp      = DPW'(ua_q) * DPW'(ub_q[UW-1 -: CW]);
		shifted = prod_q >> FRAC_BITS;
		rsat    = (shifted > LIMIT_P) ? DW'(LIMIT_P) : DW'(shifted);
		res_n   = neg_q ? (~rsat + DW'(1)) : (rsat[DW-1] ? MAXV : rsat);
	end

	// Control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			fin_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= fin_q;
			fin_q  <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= CNT_W'(NCH);
			end else if (run_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					run_q <= 1'b0;
					fin_q <= 1'b1;
				end
			end
		end
	end

	// Operands and product, most significant chunk first
	always_ff @(posedge clk) begin
		if (start) begin
			ua_q   <= mag_a;
			ub_q   <= UW'(mag_b);
			neg_q  <= a[DW-1] ^ b[DW-1];
			prod_q <= '0;
		end else if (run_q) begin
			prod_q <= (prod_q << CW) + PW'(pp);
			ub_q   <= ub_q << CW;
		end
		if (fin_q) begin
			result_q <= res_n;
		end
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

// ----- rtl/core/pidc_dp.sv -----
// Datapath: configuration registers, working registers and the saturating ALU.
module pidc_dp #(
	parameter int DATA_WIDTH = pidc_pkg::DATA_WIDTH_DEF,
	parameter int FRAC_BITS  = pidc_pkg::FRAC_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [pidc_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [pidc_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic                                accept,
	input  logic                                opcode,
	input  logic signed [31:0]                  target,
	input  logic signed [31:0]                  measured,
	input  pidc_pkg::ctl_t                      ctl,
	input  logic signed [DATA_WIDTH-1:0]        mul_result,
	output logic signed [DATA_WIDTH-1:0]        opa,
	output logic signed [DATA_WIDTH-1:0]        opb,
	output pidc_pkg::sts_t                      sts,
	output logic signed [DATA_WIDTH-1:0]        result
);
	import pidc_pkg::*;

	localparam int DW = DATA_WIDTH;
	localparam int XW = DW + 33;
	localparam logic [DW-1:0] MAXV = {1'b0, {(DW-1){1'b1}}};
	localparam logic [DW-1:0] MINV = {1'b1, {(DW-1){1'b0}}};
	localparam logic signed [XW-1:0] HI_X = {{(XW-DW+1){1'b0}}, {(DW-1){1'b1}}};
	localparam logic signed [XW-1:0] LO_X = {{(XW-DW+1){1'b1}}, {(DW-1){1'b0}}};

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_PG   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IG   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DG   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_STEP = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_OLO  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_OHI  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_ALO  = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_AHI  = 3'd7;

	// Saturate a 32-bit two's complement value to the data width
	function automatic logic [DW-1:0] sat32(input logic [31:0] x);
		logic signed [XW-1:0] xe;
		xe = {{(XW-32){x[31]}}, x};
		if (xe > HI_X) return MAXV;
		if (xe < LO_X) return MINV;
		return xe[DW-1:0];
	endfunction

	// Saturating add or subtract
	function automatic logic [DW-1:0] sat_add(input logic [DW-1:0] x, input logic [DW-1:0] y,
		input logic sub);
		logic [DW:0] s;
		s = sub ? ({x[DW-1], x} - {y[DW-1], y}) : ({x[DW-1], x} + {y[DW-1], y});
		if (s[DW] != s[DW-1]) return s[DW] ? MINV : MAXV;
		return s[DW-1:0];
	endfunction

	// Upper limit checked first: if limits cross, x > hi gives hi, else lo
	function automatic logic [DW-1:0] clampv(input logic signed [DW-1:0] x,
		input logic signed [DW-1:0] lo, input logic signed [DW-1:0] hi);
		if (x > hi) return hi;
		if (x < lo) return lo;
		return x;
	endfunction

	logic signed [DW-1:0] pg_q, ig_q, dg_q, st_q;
	logic signed [DW-1:0] olo_q, ohi_q, alo_q, ahi_q;
	logic                 op_q;
	logic signed [DW-1:0] tgt_q, meas_q;
	logic signed [DW-1:0] err_q, t_q, u_q, acc_q, last_q;
	logic signed [DW-1:0] res;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pg_q  <= '0;
			ig_q  <= '0;
			dg_q  <= '0;
			st_q  <= '0;
			olo_q <= MINV;
			ohi_q <= MAXV;
			alo_q <= MINV;
			ahi_q <= MAXV;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_PG:   pg_q  <= sat32(cfg_data);
				REG_IG:   ig_q  <= sat32(cfg_data);
				REG_DG:   dg_q  <= sat32(cfg_data);
				REG_STEP: st_q  <= sat32({1'b0, cfg_data[30:0]});
				REG_OLO:  olo_q <= sat32(cfg_data);
				REG_OHI:  ohi_q <= sat32(cfg_data);
				REG_ALO:  alo_q <= sat32(cfg_data);
				REG_AHI:  ahi_q <= sat32(cfg_data);
				default: begin
				end
			endcase
		end
	end

	// Operand selection
	function automatic logic [DW-1:0] pick(input src_t sel);
		case (sel)
			SRC_TGT:  return tgt_q;
			SRC_MEAS: return meas_q;
			SRC_ERR:  return err_q;
			SRC_T:    return t_q;
			SRC_U:    return u_q;
			SRC_ACC:  return acc_q;
			SRC_LAST: return last_q;
			SRC_STEP: return st_q;
			SRC_PG:   return pg_q;
			SRC_IG:   return ig_q;
			SRC_DG:   return dg_q;
			default:  return '0;
		endcase
	endfunction

	// ALU
	always_comb begin
		opa = pick(ctl.uw.a_sel);
		opb = pick(ctl.uw.b_sel);
		case (ctl.uw.op)
			OP_SUB:   res = sat_add(opa, opb, 1'b1);
			OP_ADD:   res = sat_add(opa, opb, 1'b0);
			OP_MUL:   res = mul_result;
			OP_CLMPA: res = clampv(opa, alo_q, ahi_q);
			OP_CLMPO: res = clampv(opa, olo_q, ohi_q);
			OP_ZERO:  res = '0;
			OP_MOVE:  res = opa;
			default:  res = opa;
		endcase
	end

	// Controller state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q  <= '0;
			last_q <= '0;
			op_q   <= 1'b0;
		end else begin
			if (accept) begin
				op_q <= opcode;
			end
			if (ctl.wr && ctl.uw.dst == DST_ACC) begin
				acc_q <= res;
			end
			if (ctl.wr && ctl.uw.dst == DST_LAST) begin
				last_q <= res;
			end
		end
	end

	// Input word and scratch registers
	always_ff @(posedge clk) begin
		if (accept) begin
			tgt_q  <= sat32(target);
			meas_q <= sat32(measured);
		end
		if (ctl.wr) begin
			case (ctl.uw.dst)
				DST_ERR: err_q <= res;
				DST_T:   t_q   <= res;
				DST_U:   u_q   <= res;
				default: begin
				end
			endcase
		end
	end

	assign sts.clr = op_q;
	assign sts.dt0 = (st_q == '0);
	assign result  = t_q;

endmodule

// ----- rtl/core/pidc_seq.sv -----
// Microcode sequencer: program counter, control store and jump logic.
module pidc_seq (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           accept,
	input  logic           emit_ok,
	input  logic           mul_done,
	input  pidc_pkg::sts_t sts,
	output pidc_pkg::ctl_t ctl,
	output logic           busy,
	output logic           emit
);
	import pidc_pkg::*;

	localparam logic [PC_W-1:0] PC_CLR  = 5'd14;
	localparam logic [PC_W-1:0] PC_ZOUT = 5'd16;
	localparam logic [PC_W-1:0] PC_NONE = 5'd0;

	function automatic uword_t mk(input alu_op_t op, input src_t a, input src_t b,
		input dst_t d, input jmp_t j, input logic [PC_W-1:0] t, input logic l);
		uword_t w;
		w.op     = op;
		w.a_sel  = a;
		w.b_sel  = b;
		w.dst    = d;
		w.jmp    = j;
		w.target = t;
		w.last   = l;
		return w;
	endfunction

	// Control store
	function automatic uword_t ucode(input logic [PC_W-1:0] pc);
		case (pc)
			// dispatch
			5'd0:  return mk(OP_NOP, SRC_TGT, SRC_TGT, DST_NONE, JMP_CLR, PC_CLR, 1'b0);
			5'd1:  return mk(OP_NOP, SRC_TGT, SRC_TGT, DST_NONE, JMP_DT0, PC_ZOUT, 1'b0);
			// error and integral
			5'd2:  return mk(OP_SUB, SRC_TGT, SRC_MEAS, DST_ERR, JMP_NONE, PC_NONE, 1'b0);
			5'd3:  return mk(OP_MUL, SRC_ERR, SRC_STEP, DST_T, JMP_NONE, PC_NONE, 1'b0);
			5'd4:  return mk(OP_ADD, SRC_ACC, SRC_T, DST_ACC, JMP_NONE, PC_NONE, 1'b0);
			5'd5:  return mk(OP_CLMPA, SRC_ACC, SRC_ACC, DST_ACC, JMP_NONE, PC_NONE, 1'b0);
			// P, I and D terms
			5'd6:  return mk(OP_MUL, SRC_PG, SRC_ERR, DST_T, JMP_NONE, PC_NONE, 1'b0);
			5'd7:  return mk(OP_MUL, SRC_IG, SRC_ACC, DST_U, JMP_NONE, PC_NONE, 1'b0);
			5'd8:  return mk(OP_ADD, SRC_T, SRC_U, DST_T, JMP_NONE, PC_NONE, 1'b0);
			5'd9:  return mk(OP_SUB, SRC_ERR, SRC_LAST, DST_U, JMP_NONE, PC_NONE, 1'b0);
			5'd10: return mk(OP_MUL, SRC_DG, SRC_U, DST_U, JMP_NONE, PC_NONE, 1'b0);
			5'd11: return mk(OP_ADD, SRC_T, SRC_U, DST_T, JMP_NONE, PC_NONE, 1'b0);
			5'd12: return mk(OP_CLMPO, SRC_T, SRC_T, DST_T, JMP_NONE, PC_NONE, 1'b0);
			5'd13: return mk(OP_MOVE, SRC_ERR, SRC_ERR, DST_LAST, JMP_NONE, PC_NONE, 1'b1);
			// clear
			5'd14: return mk(OP_ZERO, SRC_ACC, SRC_ACC, DST_ACC, JMP_NONE, PC_NONE, 1'b0);
			5'd15: return mk(OP_ZERO, SRC_ACC, SRC_ACC, DST_LAST, JMP_NONE, PC_NONE, 1'b0);
			// zero result
			5'd16: return mk(OP_ZERO, SRC_T, SRC_T, DST_T, JMP_NONE, PC_NONE, 1'b0);
			5'd17: return mk(OP_NOP, SRC_T, SRC_T, DST_NONE, JMP_NONE, PC_NONE, 1'b1);
			default: return mk(OP_NOP, SRC_T, SRC_T, DST_NONE, JMP_NONE, PC_NONE, 1'b1);
		endcase
	endfunction

	logic            busy_q;
	logic            mwait_q;
	logic [PC_W-1:0] pc_q;

	uword_t w;
	logic   is_mul;
	logic   take;
	logic   step_ok;

	// Decode current step
	always_comb begin
		w       = ucode(pc_q);
		is_mul  = (w.op == OP_MUL);
		take    = (w.jmp == JMP_CLR && sts.clr) || (w.jmp == JMP_DT0 && sts.dt0);
		step_ok = is_mul ? mul_done : (w.last ? emit_ok : 1'b1);
		ctl.uw        = w;
		ctl.wr        = busy_q && step_ok;
		ctl.mul_start = busy_q && is_mul && !mwait_q;
		emit          = busy_q && w.last && emit_ok;
	end

	// Step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			mwait_q <= 1'b0;
			pc_q    <= '0;
		end else begin
			if (accept) begin
				busy_q <= 1'b1;
				pc_q   <= '0;
			end else if (busy_q && step_ok) begin
				if (w.last) begin
					busy_q <= 1'b0;
				end else begin
					pc_q <= take ? w.target : pc_q + PC_W'(1);
				end
			end
			if (ctl.mul_start) begin
				mwait_q <= 1'b1;
			end else if (mul_done) begin
				mwait_q <= 1'b0;
			end
		end
	end

	assign busy = busy_q;

endmodule

// ----- rtl/core/pid_controller_clamped.sv -----
// Positional PID controller with clamped integral and output, signed fixed
// point (DATA_WIDTH bits, FRAC_BITS fraction bits; Q16.16 by default). One
// word is taken at a time; the next is taken only once the current one has
// written its drive value to the output register. The four multiplications
// run one after another through a single multiplier that takes 16 bits of
// one operand per cycle. A clear word zeroes the integral, the previous error
// and the drive value; a compute word with zero step_time gives zero drive
// and leaves that state alone. A finished drive value waits in the output
// register, so the next word can be taken meanwhile. Registers are to be
// written only while no word is in flight; the block does not enforce this.
`include "pid_controller_clamped_defines.svh"

module pid_controller_clamped #(
	parameter int DATA_WIDTH = pidc_pkg::DATA_WIDTH_DEF,
	parameter int FRAC_BITS  = pidc_pkg::FRAC_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [pidc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [pidc_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic                            opcode,
	input  logic signed [31:0]              target,
	input  logic signed [31:0]              measured,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic signed [31:0]              drive
);
	import pidc_pkg::*;

	localparam int DW = DATA_WIDTH;

	ctl_t                 ctl;
	sts_t                 sts;
	logic                 busy;
	logic                 emit;
	logic                 emit_ok;
	logic                 accept;
	logic                 mul_done;
	logic signed [DW-1:0] mul_result;
	logic signed [DW-1:0] opa, opb;
	logic signed [DW-1:0] result;
	logic [DW+31:0]       result_x;

	logic                 out_valid_q;
	logic signed [31:0]   drive_q;

	assign accept   = in_valid && !busy;
	assign in_stall = busy;
	assign emit_ok  = !out_valid_q || !out_stall;
	assign result_x = {{32{result[DW-1]}}, result};

	pidc_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.emit_ok  (emit_ok),
		.mul_done (mul_done),
		.sts      (sts),
		.ctl      (ctl),
		.busy     (busy),
		.emit     (emit)
	);

	pidc_dp #(
		.DATA_WIDTH (DATA_WIDTH),
		.FRAC_BITS  (FRAC_BITS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.accept     (accept),
		.opcode     (opcode),
		.target     (target),
		.measured   (measured),
		.ctl        (ctl),
		.mul_result (mul_result),
		.opa        (opa),
		.opb        (opb),
		.sts        (sts),
		.result     (result)
	);

	pidc_mul #(
		.DATA_WIDTH (DATA_WIDTH),
		.FRAC_BITS  (FRAC_BITS)
	) u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (ctl.mul_start),
		.a      (opa),
		.b      (opb),
		.done   (mul_done),
		.result (mul_result)
	);

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			drive_q <= result_x[31:0];
		end
	end

	assign out_valid = out_valid_q;
	assign drive     = drive_q;

	// Checks
	`PIDC_ASSERT_NEXT(a_busy_after_accept, accept, in_stall, "word accepted while not busy after")
	`PIDC_ASSERT_NOW(a_no_overwrite, emit, !out_valid || !out_stall, "result overwrote held word")
	`PIDC_ASSERT_NOW(a_valid_from_emit, $rose(out_valid), $past(emit), "output valid without emit")
	`PIDC_ASSERT_NEXT(a_idle_after_emit, emit, !in_stall, "sequencer still busy after emit")

endmodule

// ----- tb/tb_pid_controller_clamped.sv -----
module tb_pid_controller_clamped;

	// Word opcodes
	localparam logic WORD_STEP  = 1'b0;
	localparam logic WORD_CLEAR = 1'b1;

	// Register map
	typedef logic [pidc_pkg::CFG_IDX_W-1:0] reg_idx_t;
	localparam reg_idx_t REG_PROP_GAIN  = 3'd0;
	localparam reg_idx_t REG_INTEG_GAIN = 3'd1;
	localparam reg_idx_t REG_DERIV_GAIN = 3'd2;
	localparam reg_idx_t REG_STEP_TIME  = 3'd3;
	localparam reg_idx_t REG_OUT_LOWER  = 3'd4;
	localparam reg_idx_t REG_OUT_UPPER  = 3'd5;
	localparam reg_idx_t REG_ACC_LOWER  = 3'd6;
	localparam reg_idx_t REG_ACC_UPPER  = 3'd7;

	localparam int FRAC        = 16;
	localparam int CFG_SETTLE  = 4;
	localparam int TAIL_CYCLES = 40;
	localparam int LONG_HOLD   = 300;
	localparam int STALE_LIMIT = 4000;
	localparam int BATCH_WORDS = 160;

	localparam longint SAT_HI = 64'sd2147483647;
	localparam longint SAT_LO = -64'sd2147483648;

	// Q16.16 constants
	localparam logic [31:0] Q_ONE   = 32'h0001_0000;
	localparam logic [31:0] Q_MIN   = 32'h8000_0000;
	localparam logic [31:0] Q_MAX   = 32'h7FFF_FFFF;

	typedef struct packed {
		logic        op;
		logic [31:0] tgt;
		logic [31:0] meas;
	} pid_word_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [pidc_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [pidc_pkg::CFG_DATA_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic opcode = 1'b0;
	logic signed [31:0] target = '0;
	logic signed [31:0] measured = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [31:0] drive;

	pid_word_t word_queue[$];
	logic [31:0] drive_expected[$];
	pid_word_t next_word;
	logic [31:0] drive_want;

	// Controller state and register shadows
	longint cfg_shadow [8];
	longint integ_state = 0;
	longint prev_error = 0;

	int queued_count = 0;
	int taken_count = 0;
	int checked_count = 0;
	int fail_count = 0;
	int send_gap_pct = 0;
	int recv_stall_pct = 0;
	int hold_asks = 0;
	int hold_given = 0;
	int hold_left = 0;
	int stale_cycles = 0;

	pid_controller_clamped dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.opcode    (opcode),
		.target    (target),
		.measured  (measured),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.drive     (drive)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Fixed-point arithmetic
	function automatic longint sat32(longint x);
		if (x > SAT_HI) return SAT_HI;
		if (x < SAT_LO) return SAT_LO;
		return x;
	endfunction

	// Product shifted by FRAC, magnitude truncated, saturated
	function automatic longint fx_mul(longint a, longint b);
		logic neg;
		longint unsigned ua, ub, mag;
		neg = (a < 0) != (b < 0);
		ua = (a < 0) ? -a : a;
		ub = (b < 0) ? -b : b;
		mag = (ua * ub) >> FRAC;
		if (mag > 64'd2147483648) mag = 64'd2147483648;
		if (neg) return -longint'(mag);
		if (mag > 64'd2147483647) return SAT_HI;
		return longint'(mag);
	endfunction

	// Crossed limits: x > hi gives hi, anything else gives lo
	function automatic longint clamp_to(longint x, longint lo, longint hi);
		if (x > hi) return hi;
		if (x < lo) return lo;
		return x;
	endfunction

	// Next drive value; updates integral and previous error
	function automatic logic [31:0] predict_drive(logic op, logic signed [31:0] tgt,
			logic signed [31:0] meas);
		longint err, p, i, d, y;
		if (op == WORD_CLEAR) begin
			integ_state = 0;
			prev_error = 0;
			return 32'h0;
		end
		if (cfg_shadow[REG_STEP_TIME] == 0) return 32'h0;
		err = sat32(longint'(tgt) - longint'(meas));
		integ_state = sat32(integ_state + fx_mul(err, cfg_shadow[REG_STEP_TIME]));
		integ_state = clamp_to(integ_state, cfg_shadow[REG_ACC_LOWER],
			cfg_shadow[REG_ACC_UPPER]);
		p = fx_mul(cfg_shadow[REG_PROP_GAIN], err);
		i = fx_mul(cfg_shadow[REG_INTEG_GAIN], integ_state);
		d = fx_mul(cfg_shadow[REG_DERIV_GAIN], sat32(err - prev_error));
		y = sat32(sat32(p + i) + d);
		y = clamp_to(y, cfg_shadow[REG_OUT_LOWER], cfg_shadow[REG_OUT_UPPER]);
		prev_error = err;
		return y[31:0];
	endfunction

	// Random values
	function automatic logic [31:0] pick_edge();
		case ($urandom_range(4))
			0: return Q_MIN;
			1: return Q_MAX;
			2: return 32'h0;
			3: return 32'hFFFF_FFFF;
			default: return Q_ONE;
		endcase
	endfunction

	function automatic logic [31:0] pick_scaled(int unsigned span);
		return $urandom_range(2 * span) - span;
	endfunction

	function automatic logic [31:0] pick_operand();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 10) return pick_edge();
		if (r < 65) return pick_scaled(32'h0100_0000);
		return $urandom;
	endfunction

	function automatic logic [31:0] pick_gain();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 15) return pick_edge();
		if (r < 80) return pick_scaled(32'h0004_0000);
		return $urandom;
	endfunction

	// Bit 31 is set now and then; the register ignores it
	function automatic logic [31:0] pick_step();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 8) return 32'h0;
		if (r < 16) return $urandom;
		return $urandom_range(32'h0002_0000) | ($urandom_range(1) << 31);
	endfunction

	function automatic void note_failure(string msg);
		if (fail_count < 10) $display("%s", msg);
		fail_count++;
	endfunction

	task automatic push_word(logic op, logic [31:0] tgt, logic [31:0] meas);
		word_queue.push_back('{op: op, tgt: tgt, meas: meas});
		queued_count++;
	endtask

	// Leaves write enable high; caller lowers it after the last write
	task automatic write_reg(reg_idx_t idx, logic [31:0] value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		if (idx == REG_STEP_TIME) cfg_shadow[idx] = longint'({1'b0, value[30:0]});
		else cfg_shadow[idx] = longint'($signed(value));
	endtask

	task automatic load_config(logic [31:0] pg, logic [31:0] ig, logic [31:0] dg,
			logic [31:0] st, logic [31:0] ol, logic [31:0] ou, logic [31:0] al,
			logic [31:0] au);
		write_reg(REG_PROP_GAIN, pg);
		write_reg(REG_INTEG_GAIN, ig);
		write_reg(REG_DERIV_GAIN, dg);
		write_reg(REG_STEP_TIME, st);
		write_reg(REG_OUT_LOWER, ol);
		write_reg(REG_OUT_UPPER, ou);
		write_reg(REG_ACC_LOWER, al);
		write_reg(REG_ACC_UPPER, au);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Limit pairs: full range, crossed, or an ordered random window
	task automatic random_config();
		logic [31:0] lim [4];
		logic [31:0] a, b;
		int unsigned r;
		for (int k = 0; k < 2; k++) begin
			r = $urandom_range(99);
			a = pick_scaled(32'h0100_0000);
			b = pick_scaled(32'h0100_0000);
			if (r < 15) begin
				lim[2*k] = Q_MIN;
				lim[2*k+1] = Q_MAX;
			end else if ((r < 25) == ($signed(a) < $signed(b))) begin
				lim[2*k] = b;
				lim[2*k+1] = a;
			end else begin
				lim[2*k] = a;
				lim[2*k+1] = b;
			end
		end
		load_config(pick_gain(), pick_gain(), pick_gain(), pick_step(),
			lim[0], lim[1], lim[2], lim[3]);
	endtask

	// Block idle: every queued word taken and its result checked
	task automatic wait_drained();
		while (taken_count != queued_count || checked_count != queued_count)
			@(posedge clk);
		repeat (CFG_SETTLE) @(posedge clk);
	endtask

	// Clears kept rare so the integral has room to build
	task automatic run_batch(int n, bit pause_midway);
		for (int k = 0; k < n; k++) begin
			if (pause_midway && k == n / 2) wait_drained();
			push_word(($urandom_range(99) < 4) ? WORD_CLEAR : WORD_STEP,
				pick_operand(), pick_operand());
		end
	endtask

	// Driver: offer queued words, predict each accepted one
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && !in_stall) begin
				drive_expected.push_back(predict_drive(opcode, target, measured));
				taken_count++;
			end
			if (!in_valid || !in_stall) begin
				if (word_queue.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
					next_word = word_queue.pop_front();
					in_valid <= 1'b1;
					opcode <= next_word.op;
					target <= next_word.tgt;
					measured <= next_word.meas;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: compare results, drive the output stall
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (drive_expected.size() == 0) begin
					note_failure($sformatf("unexpected drive word %h", drive));
				end else begin
					drive_want = drive_expected.pop_front();
					if (drive !== drive_want)
						note_failure($sformatf("drive mismatch: expected %h, got %h",
							drive_want, drive));
					checked_count++;
				end
			end
			if (hold_given != hold_asks) begin
				hold_given = hold_asks;
				hold_left = LONG_HOLD;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= ($urandom_range(99) < recv_stall_pct);
			end
		end
	end

	// Cycles with no word moving on either side
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stale_cycles <= 0;
		end else if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			stale_cycles <= 0;
		end else begin
			stale_cycles <= stale_cycles + 1;
		end
	end

	initial begin
		wait (stale_cycles >= STALE_LIMIT);
		$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		cfg_shadow[REG_PROP_GAIN] = 0;
		cfg_shadow[REG_INTEG_GAIN] = 0;
		cfg_shadow[REG_DERIV_GAIN] = 0;
		cfg_shadow[REG_STEP_TIME] = 0;
		cfg_shadow[REG_OUT_LOWER] = SAT_LO;
		cfg_shadow[REG_OUT_UPPER] = SAT_HI;
		cfg_shadow[REG_ACC_LOWER] = SAT_LO;
		cfg_shadow[REG_ACC_UPPER] = SAT_HI;
		repeat (11) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		// Reset config: zero step time gives zero drive
		push_word(WORD_STEP, Q_MAX, Q_MIN);
		push_word(WORD_CLEAR, 32'h0, 32'h0);
		wait_drained();

		// Moderate gains, +/-100 output, +/-50 integral
		load_config(Q_ONE, 32'h0000_8000, 32'h0000_4000, Q_ONE,
			32'hFF9C_0000, 32'h0064_0000, 32'hFFCE_0000, 32'h0032_0000);
		push_word(WORD_STEP, Q_MAX, Q_MIN);
		push_word(WORD_STEP, Q_MIN, Q_MAX);
		push_word(WORD_STEP, 32'h0, 32'h0);
		push_word(WORD_STEP, 32'h0003_0000, Q_ONE);
		push_word(WORD_STEP, 32'h0003_0000, Q_ONE);
		push_word(WORD_CLEAR, Q_MAX, Q_MAX);
		push_word(WORD_STEP, 32'hFFFE_0000, 32'h0000_8000);
		wait_drained();

		// Crossed output and integral limits
		load_config(Q_ONE, 32'h0000_8000, 32'h0000_4000, Q_ONE,
			32'h000A_0000, 32'hFFF6_0000, 32'h0005_0000, 32'hFFFB_0000);
		push_word(WORD_STEP, Q_ONE, 32'h0);
		push_word(WORD_STEP, 32'hFFFF_0000, 32'h0);
		push_word(WORD_STEP, 32'h0, 32'h0);
		wait_drained();

		// Extreme gains; step time written with bit 31 set
		load_config(Q_MIN, Q_MAX, Q_MIN, 32'hFFFF_FFFF, Q_MIN, Q_MAX, Q_MIN, Q_MAX);
		push_word(WORD_STEP, Q_MAX, Q_MIN);
		push_word(WORD_STEP, Q_MIN, Q_MAX);
		push_word(WORD_STEP, Q_ONE, 32'h0);
		push_word(WORD_STEP, 32'hFFFF_0000, 32'h0);
		push_word(WORD_STEP, 32'h0, 32'h1);
		push_word(WORD_CLEAR, 32'h0, 32'h0);
		wait_drained();

		// Zero step time mid-run leaves the state alone
		load_config(Q_ONE, 32'h0000_8000, 32'h0000_4000, Q_ONE,
			Q_MIN, Q_MAX, Q_MIN, Q_MAX);
		push_word(WORD_STEP, 32'h0005_0000, 32'h0);
		wait_drained();
		write_reg(REG_STEP_TIME, 32'h0);
		@(posedge clk);
		cfg_we <= 1'b0;
		push_word(WORD_STEP, 32'h0007_0000, 32'h0);
		wait_drained();
		write_reg(REG_STEP_TIME, Q_ONE);
		@(posedge clk);
		cfg_we <= 1'b0;
		push_word(WORD_STEP, 32'h0007_0000, 32'h0);

		// Random part over three idling modes
		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					send_gap_pct = 24;
					recv_stall_pct = 70;
				end
				1: begin
					send_gap_pct = 70;
					recv_stall_pct = 24;
				end
				default: begin
					send_gap_pct = 0;
					recv_stall_pct = 0;
				end
			endcase
			for (int set = 0; set < 4; set++) begin
				wait_drained();
				random_config();
				if (phase == 2 && set == 1) begin
					@(posedge clk);
					hold_asks <= hold_asks + 1;
				end
				run_batch(BATCH_WORDS, phase == 1 && set == 2);
			end
		end

		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (fail_count == 0 && drive_expected.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
